/* hdl/gcr_pkg.sv */
// Package for the great-circle range pipeline: beat types, fixed-point constants,
// CORDIC tables and the split-multiply helpers.
// No dependencies.
package gcr_pkg;

  localparam int CORDIC_STAGES = 24;
  // Register stages from input beat to result beat
  localparam int PIPE_DEPTH    = 2 * CORDIC_STAGES + 47;

  // Fixed-point constants (Q60 angles, Q62 unity)
  localparam logic [63:0] PI_Q60        = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_PI_Q60   = PI_Q60 >> 1;
  localparam logic [63:0] ONE_Q62       = 64'h4000000000000000;
  localparam logic [63:0] INV_SQRT2_Q62 = 64'hB504F333F9DE6484 >> 2;
  localparam logic [63:0] DEG7_FULL     = (PI_Q60 + 64'd900000000) / 64'd1800000000;
  localparam logic [30:0] DEG7_TO_Q60   = DEG7_FULL[30:0];
  localparam logic [26:0] TWO_R_DM      = 27'd127420176;
  localparam logic [91:0] ROUND_HALF    = 92'd5 << 60;
  localparam logic [31:0] RECIP_10      = 32'hCCCCCCCD;
  localparam int          RECIP_SHIFT   = 35;
  localparam logic [24:0] DIST_MAX      = 25'd20015115;

  localparam logic signed [31:0] LAT_LIMIT = 32'sd900000000;
  localparam logic signed [31:0] LON_LIMIT = 32'sd1800000000;

  // Configuration register indexes
  localparam int          CFG_IDX_W     = 2;
  localparam logic [1:0]  REG_REF_VALID = 2'd0;
  localparam logic [1:0]  REG_REF_LAT   = 2'd1;
  localparam logic [1:0]  REG_REF_LON   = 2'd2;

  typedef struct packed {
    logic signed [31:0] target_lat;
    logic signed [31:0] target_lon;
  } gcr_in_t;

  typedef struct packed {
    logic [24:0] distance_m;
    logic        unknown;
  } gcr_out_t;

  typedef logic [CORDIC_STAGES-1:0][63:0] gcr_tab_t;

  // Four 32x32 partial products of a 64x64 multiply
  typedef struct packed {
    logic [63:0] p11;
    logic [63:0] p10;
    logic [63:0] p01;
    logic [63:0] p00;
  } gcr_pp_t;

  // Partial products with the two cross terms folded
  typedef struct packed {
    logic [63:0] hi;
    logic [64:0] mid;
    logic [63:0] lo;
  } gcr_pmid_t;

  // atan(2^-i) in Q60 from the alternating integer series
  function automatic gcr_tab_t atan_table();
    gcr_tab_t    tab;
    logic [63:0] s;
    logic [63:0] term;
    int          e;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (i == 0) begin
        tab[i] = PI_Q60 >> 2;
      end else begin
        s = 64'd0;
        for (int k = 0; k < 64; k++) begin
          e = 63 - i * (2 * k + 1);
          if (e >= 0) begin
            term = (64'd1 << e) / 64'(2 * k + 1);
            if ((k & 1) != 0) s = s - term;
            else s = s + term;
          end
        end
        tab[i] = (s + 64'd4) >> 3;
      end
    end
    return tab;
  endfunction

  // Start vector length: product of 1/sqrt(1+4^-i), Q62 rounded to Q60
  function automatic logic [63:0] gain_start();
    logic [63:0]  k62;
    logic [63:0]  f;
    logic [63:0]  t;
    logic [127:0] p;
    int           sh;
    k62 = ONE_Q62;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (i == 0) begin
        f = INV_SQRT2_Q62;
      end else begin
        f  = ONE_Q62;
        t  = ONE_Q62;
        sh = 2 * i;
        for (int k = 1; k <= 64; k++) begin
          t = (sh >= 64) ? 64'd0 : (t >> sh);
          t = t - t / 64'(2 * k);
          if ((k & 1) != 0) f = f - t;
          else f = f + t;
        end
      end
      p   = {64'd0, k62} * {64'd0, f};
      k62 = p[125:62];
    end
    return (k62 + 64'd2) >> 2;
  endfunction

  localparam gcr_tab_t    ATAN_Q60 = atan_table();
  localparam logic [63:0] GAIN_Q60 = gain_start();

  function automatic gcr_pp_t mul_parts(input logic [63:0] a, input logic [63:0] b);
    gcr_pp_t pp;
    pp.p00 = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
    pp.p01 = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
    pp.p10 = {32'd0, a[63:32]} * {32'd0, b[31:0]};
    pp.p11 = {32'd0, a[63:32]} * {32'd0, b[63:32]};
    return pp;
  endfunction

  function automatic gcr_pmid_t mid_sum(input gcr_pp_t pp);
    gcr_pmid_t m;
    m.hi  = pp.p11;
    m.mid = {1'b0, pp.p01} + {1'b0, pp.p10};
    m.lo  = pp.p00;
    return m;
  endfunction

  function automatic logic [127:0] full_sum(input gcr_pmid_t m);
    return {m.hi, 64'd0} + {31'd0, m.mid, 32'd0} + {64'd0, m.lo};
  endfunction

endpackage

/* hdl/great_circle_range_from_reference.sv */
// Haversine great-circle range pipeline, top level.
// Depends on gcr_pkg (types, constants, CORDIC tables, multiply helpers).
//
// Takes one target position per cycle (1e-7 degree units) and returns the
// great-circle distance in metres from the reference set through the cfg_
// port, or the unknown flag when the reference is not installed or a
// position is out of range. The pipe holds input and angle scaling, a
// 24-stage rotation CORDIC (four lanes), two split 64-bit multiplies, two
// 32-stage square-root pipes, a 24-stage vectoring CORDIC and the metre
// scaling. Throughput is one beat per cycle; a stall at the output holds
// the whole pipe, so in_ready follows out_ready whenever the output
// register is full. Write the reference only while the pipe is empty.
module great_circle_range_from_reference (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  gcr_pkg::gcr_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output gcr_pkg::gcr_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [gcr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_wdata
);

  localparam int N     = gcr_pkg::CORDIC_STAGES;
  localparam int DEPTH = gcr_pkg::PIPE_DEPTH;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // Reference registers
  logic        ref_valid_r;
  logic [30:0] ref_lat_r;
  logic [31:0] ref_lon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_valid_r <= 1'b0;
      ref_lat_r   <= '0;
      ref_lon_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gcr_pkg::REG_REF_VALID: ref_valid_r <= cfg_wdata[0];
        gcr_pkg::REG_REF_LAT:   ref_lat_r   <= cfg_wdata[30:0];
        gcr_pkg::REG_REF_LON:   ref_lon_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipe control: everything advances together unless the output is held
  logic             adv;
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] unk_r;
  logic             in_unknown;

  assign adv      = !vld_r[DEPTH-1] || out_ready;
  assign in_ready = adv;

  // Range check of the incoming beat against the reference
  logic signed [31:0] rlat_ext;
  assign rlat_ext   = {ref_lat_r[30], ref_lat_r};
  assign in_unknown = !ref_valid_r ||
                      (in_data.target_lat < -gcr_pkg::LAT_LIMIT) ||
                      (in_data.target_lat >  gcr_pkg::LAT_LIMIT) ||
                      (in_data.target_lon < -gcr_pkg::LON_LIMIT) ||
                      (in_data.target_lon >  gcr_pkg::LON_LIMIT) ||
                      (rlat_ext < -gcr_pkg::LAT_LIMIT) ||
                      (rlat_ext >  gcr_pkg::LAT_LIMIT) ||
                      ($signed(ref_lon_r) < -gcr_pkg::LON_LIMIT) ||
                      ($signed(ref_lon_r) >  gcr_pkg::LON_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) unk_r <= {unk_r[DEPTH-2:0], in_unknown};
  end

  // Stage 1: differences and magnitudes
  logic signed [32:0] dlat;
  logic signed [32:0] dlon;
  logic [32:0]        s1_dlat_r;
  logic [32:0]        s1_dlon_r;
  logic [30:0]        s1_rlat_r;
  logic [31:0]        s1_tlat_r;

  assign dlat = {in_data.target_lat[31], in_data.target_lat} -
                {{2{ref_lat_r[30]}}, ref_lat_r};
  assign dlon = {in_data.target_lon[31], in_data.target_lon} -
                {ref_lon_r[31], ref_lon_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dlat_r <= dlat[32] ? (~dlat + 33'd1) : dlat;
      s1_dlon_r <= dlon[32] ? (~dlon + 33'd1) : dlon;
      s1_rlat_r <= ref_lat_r[30] ? (~ref_lat_r + 31'd1) : ref_lat_r;
      s1_tlat_r <= in_data.target_lat[31] ? (~in_data.target_lat + 32'd1)
                                          : in_data.target_lat;
    end
  end

  // Stage 2: scale to Q60 radians; halve the differences
  logic [63:0] p_dlat, p_dlon, p_rlat, p_tlat;
  logic [3:0][63:0] s2_ang_r;

  assign p_dlat = 64'(s1_dlat_r) * 64'(gcr_pkg::DEG7_TO_Q60);
  assign p_dlon = 64'(s1_dlon_r) * 64'(gcr_pkg::DEG7_TO_Q60);
  assign p_rlat = 64'(s1_rlat_r) * 64'(gcr_pkg::DEG7_TO_Q60);
  assign p_tlat = 64'(s1_tlat_r) * 64'(gcr_pkg::DEG7_TO_Q60);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ang_r[0] <= p_dlat >> 1;
      s2_ang_r[1] <= p_dlon >> 1;
      s2_ang_r[2] <= p_rlat;
      s2_ang_r[3] <= p_tlat;
    end
  end

  // Stage 3: saturate at pi and fold into the first quadrant
  logic signed [63:0] s3_z_r [4];

  always_ff @(posedge clk) begin : p_fold
    logic [63:0] a;
    if (adv) begin
      for (int g = 0; g < 4; g++) begin
        a = (s2_ang_r[g] > gcr_pkg::PI_Q60) ? gcr_pkg::PI_Q60 : s2_ang_r[g];
        if (a > gcr_pkg::HALF_PI_Q60) a = gcr_pkg::PI_Q60 - a;
        s3_z_r[g] <= $signed(a);
      end
    end
  end

  // Rotation CORDIC, four lanes, one iteration per stage
  logic signed [63:0] rx_r [4][N];
  logic signed [63:0] ry_r [4][N];
  logic signed [63:0] rz_r [4][N];

  always_ff @(posedge clk) begin : p_rot
    logic signed [63:0] x, y, z, dx, dy, at;
    if (adv) begin
      for (int g = 0; g < 4; g++) begin
        for (int i = 0; i < N; i++) begin
          if (i == 0) begin
            x = $signed(gcr_pkg::GAIN_Q60);
            y = '0;
            z = s3_z_r[g];
          end else begin
            x = rx_r[g][i-1];
            y = ry_r[g][i-1];
            z = rz_r[g][i-1];
          end
          dx = y >>> i;
          dy = x >>> i;
          at = $signed(gcr_pkg::ATAN_Q60[i]);
          if (!z[63]) begin
            rx_r[g][i] <= x - dx;
            ry_r[g][i] <= y + dy;
            rz_r[g][i] <= z - at;
          end else begin
            rx_r[g][i] <= x + dx;
            ry_r[g][i] <= y - dy;
            rz_r[g][i] <= z + at;
          end
        end
      end
    end
  end

  // Magnitudes: half-difference sines and the two latitude cosines
  logic [63:0] ab_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      ab_r[0] <= mag64(ry_r[0][N-1]);
      ab_r[1] <= mag64(ry_r[1][N-1]);
      ab_r[2] <= mag64(rx_r[2][N-1]);
      ab_r[3] <= mag64(rx_r[3][N-1]);
    end
  end

  // Split multiply A: sin^2 terms (Q62) and the cosine product (Q60)
  gcr_pkg::gcr_pp_t   pa_r [3];
  gcr_pkg::gcr_pmid_t ma_r [3];
  logic [63:0]        fa_r [3];
  logic [127:0]       fa_full [3];

  always_comb begin
    for (int g = 0; g < 3; g++) fa_full[g] = gcr_pkg::full_sum(ma_r[g]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r[0] <= gcr_pkg::mul_parts(ab_r[0], ab_r[0]);
      pa_r[1] <= gcr_pkg::mul_parts(ab_r[1], ab_r[1]);
      pa_r[2] <= gcr_pkg::mul_parts(ab_r[2], ab_r[3]);
      for (int g = 0; g < 3; g++) ma_r[g] <= gcr_pkg::mid_sum(pa_r[g]);
      fa_r[0] <= fa_full[0][121:58];
      fa_r[1] <= fa_full[1][121:58];
      fa_r[2] <= fa_full[2][123:60];
    end
  end

  // Split multiply B: cosine product times the longitude term
  gcr_pkg::gcr_pp_t   pb_r;
  gcr_pkg::gcr_pmid_t mb_r;
  logic [63:0]        fb_r;
  logic [63:0]        pb_sq1_r, mb_sq1_r, fb_sq1_r;
  logic [127:0]       fb_full;

  assign fb_full = gcr_pkg::full_sum(mb_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      pb_r     <= gcr_pkg::mul_parts(fa_r[2], fa_r[1]);
      mb_r     <= gcr_pkg::mid_sum(pb_r);
      fb_r     <= fb_full[123:60];
      pb_sq1_r <= fa_r[0];
      mb_sq1_r <= pb_sq1_r;
      fb_sq1_r <= mb_sq1_r;
    end
  end

  // Haversine term, clamped to unity
  logic [63:0] hav_sum;
  logic [63:0] cl_a_r;

  assign hav_sum = fb_sq1_r + fb_r;

  always_ff @(posedge clk) begin
    if (adv) cl_a_r <= (hav_sum > gcr_pkg::ONE_Q62) ? gcr_pkg::ONE_Q62 : hav_sum;
  end

  // Square roots of a and 1-a, one result bit per stage
  logic [63:0] sq_n_r [2][32];
  logic [63:0] sq_r_r [2][32];

  always_ff @(posedge clk) begin : p_sqrt
    logic [63:0] n, r, b, t;
    if (adv) begin
      for (int g = 0; g < 2; g++) begin
        for (int j = 0; j < 32; j++) begin
          if (j == 0) begin
            n = (g == 0) ? cl_a_r : (gcr_pkg::ONE_Q62 - cl_a_r);
            r = '0;
          end else begin
            n = sq_n_r[g][j-1];
            r = sq_r_r[g][j-1];
          end
          b = 64'd1 << (62 - 2 * j);
          t = r + b;
          if (n >= t) begin
            sq_n_r[g][j] <= n - t;
            sq_r_r[g][j] <= (r >> 1) + b;
          end else begin
            sq_n_r[g][j] <= n;
            sq_r_r[g][j] <= r >> 1;
          end
        end
      end
    end
  end

  // Vectoring CORDIC: angle of (sqrt(1-a), sqrt(a))
  logic signed [63:0] vx_r [N];
  logic signed [63:0] vy_r [N];
  logic signed [63:0] vz_r [N];

  always_ff @(posedge clk) begin : p_vec
    logic signed [63:0] x, y, z, dx, dy, at;
    if (adv) begin
      for (int i = 0; i < N; i++) begin
        if (i == 0) begin
          x = $signed({sq_r_r[1][31][34:0], 29'd0});
          y = $signed({sq_r_r[0][31][34:0], 29'd0});
          z = '0;
        end else begin
          x = vx_r[i-1];
          y = vy_r[i-1];
          z = vz_r[i-1];
        end
        dx = y >>> i;
        dy = x >>> i;
        at = $signed(gcr_pkg::ATAN_Q60[i]);
        if (!y[63]) begin
          vx_r[i] <= x + dx;
          vy_r[i] <= y - dy;
          vz_r[i] <= z + at;
        end else begin
          vx_r[i] <= x - dx;
          vy_r[i] <= y + dy;
          vz_r[i] <= z - at;
        end
      end
    end
  end

  // Metre scaling: 2R*z in decimetres plus half a metre, divide by ten via reciprocal
  logic [63:0] zc;
  logic [58:0] d1_p0_r, d1_p1_r;
  logic [91:0] d2_sum;
  logic [31:0] d2_v_r;
  logic [63:0] d3_prod_r;
  logic [28:0] d4_q;
  logic [24:0] dist_r;

  assign zc     = vz_r[N-1][63] ? 64'd0 : vz_r[N-1];
  assign d2_sum = {33'd0, d1_p0_r} + {1'b0, d1_p1_r, 32'd0} + gcr_pkg::ROUND_HALF;
  assign d4_q   = d3_prod_r[63:gcr_pkg::RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_p0_r   <= 59'(zc[31:0])  * 59'(gcr_pkg::TWO_R_DM);
      d1_p1_r   <= 59'(zc[63:32]) * 59'(gcr_pkg::TWO_R_DM);
      d2_v_r    <= d2_sum[91:60];
      d3_prod_r <= 64'(d2_v_r) * 64'(gcr_pkg::RECIP_10);
      if (unk_r[DEPTH-2]) dist_r <= '0;
      else if (d4_q > {4'd0, gcr_pkg::DIST_MAX}) dist_r <= gcr_pkg::DIST_MAX;
      else dist_r <= d4_q[24:0];
    end
  end

  // Result beat
  assign out_valid           = vld_r[DEPTH-1];
  assign out_data.distance_m = dist_r;
  assign out_data.unknown    = unk_r[DEPTH-1];

`ifndef SYNTHESIS
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.unknown |-> out_data.distance_m == '0)
    else $error("unknown result carries a non-zero distance");

  a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.distance_m <= gcr_pkg::DIST_MAX)
    else $error("distance beyond half circumference");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while the pipe is held");
`endif

endmodule
